@@ rtl/dtpq_pkg.sv @@
package dtpq_pkg;

	// queue geometry
	localparam int DEPTH = 64;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CAP_W = 7;
	localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
	localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(DEPTH);

	// payload widths
	localparam int TAG_W = 16;
	localparam int SIZE_W = 16;
	localparam int TIME_W = 48;
	localparam int LEN_W = 7;
	localparam int DROP_W = 32;

	// operation codes
	localparam logic FUNC_ENQ = 1'b0;
	localparam logic FUNC_DEQ = 1'b1;

	typedef enum logic [1:0] {
		ST_ENQ   = 2'd0,
		ST_DROP  = 2'd1,
		ST_DEQ   = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	typedef logic [CNT_W-1:0] cnt_t;

	// one stored descriptor
	typedef struct packed {
		logic [TAG_W-1:0]  tag;
		logic [SIZE_W-1:0] size;
		logic [TIME_W-1:0] arrival;
	} entry_t;

	// decision of the control unit for the cell row
	typedef struct packed {
		logic    push;
		logic    pop;
		status_t status;
	} ctl_t;

endpackage

@@ rtl/dtpq_cell.sv @@
module dtpq_cell
	import dtpq_pkg::*;
(
	input  logic   clk,
	input  logic   shift,
	input  logic   load,
	input  entry_t next_entry,
	input  entry_t in_entry,
	output entry_t entry
);

	entry_t entry_q;

	// take the neighbour's entry on a dequeue, the new descriptor when this is the tail slot
	always_ff @(posedge clk) begin
		if (shift) begin
			entry_q <= next_entry;
		end else if (load) begin
			entry_q <= in_entry;
		end
	end

	assign entry = entry_q;

endmodule

@@ rtl/dtpq_ctrl.sv @@
module dtpq_ctrl
	import dtpq_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic              func,
	input  logic [SIZE_W-1:0] packet_size,
	input  logic              cfg_wr_en,
	input  logic [CAP_W-1:0]  cfg_wr_data,
	output ctl_t              ctl,
	output cnt_t              count,
	output cnt_t              count_next,
	output logic [DROP_W-1:0] drop_next
);

	logic [CAP_W-1:0]  capacity_q;
	cnt_t              count_q;
	logic [DROP_W-1:0] drop_q;

	logic [CMP_W-1:0]  cap_ext;
	logic [CMP_W-1:0]  limit;
	logic              full;
	logic [DROP_W:0]   drop_sum;
	logic [DROP_W-1:0] drop_sat;

	// effective limit: capacity when set and below the row length
	always_comb begin
		cap_ext = CMP_W'(capacity_q);
		limit = ((capacity_q != '0) && (cap_ext < DEPTH_C)) ? cap_ext : DEPTH_C;
		full = CMP_W'(count_q) >= limit;
		drop_sum = {1'b0, drop_q} + (DROP_W + 1)'(packet_size);
		drop_sat = drop_sum[DROP_W] ? '1 : drop_sum[DROP_W-1:0];
	end

	// decide the transaction outcome
	always_comb begin
		ctl = '{push: 1'b0, pop: 1'b0, status: ST_ENQ};
		count_next = count_q;
		drop_next = drop_q;
		if (func == FUNC_ENQ) begin
			if (full) begin
				ctl.status = ST_DROP;
				drop_next = drop_sat;
			end else begin
				ctl.push = accept;
				ctl.status = ST_ENQ;
				count_next = count_q + cnt_t'(1);
			end
		end else begin
			if (count_q == '0) begin
				ctl.status = ST_EMPTY;
			end else begin
				ctl.pop = accept;
				ctl.status = ST_DEQ;
				count_next = count_q - cnt_t'(1);
			end
		end
	end

	// fill count, drop counter and capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= '0;
			count_q <= '0;
			drop_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				capacity_q <= cfg_wr_data;
			end
			if (accept) begin
				count_q <= count_next;
				drop_q <= drop_next;
			end
		end
	end

	assign count = count_q;

endmodule

@@ rtl/drop_tail_packet_queue.sv @@
// Drop-tail FIFO of packet descriptors built as a row of DEPTH cells; the oldest entry
// always sits in the first cell and a dequeue moves every cell one place towards it.
// One transaction (enqueue or dequeue, chosen by func) is taken per clock cycle while
// in_stall is low, and its result appears in the output register on the following
// cycle. in_stall rises only while a result waits in the output register and
// out_stall holds it. An enqueue on a full queue (at capacity, or at DEPTH when capacity
// is zero or larger) is dropped and its size added to a saturating byte counter. The
// user must write capacity through cfg_wr_en/cfg_wr_data only while the block is idle,
// which the block does not enforce; after reset capacity is zero and the queue is empty.
module drop_tail_packet_queue
	import dtpq_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              func,
	input  logic [TAG_W-1:0]  packet_tag,
	input  logic [SIZE_W-1:0] packet_size,
	input  logic [TIME_W-1:0] now_time,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [1:0]        status,
	output logic [TAG_W-1:0]  out_tag,
	output logic [SIZE_W-1:0] out_size,
	output logic [TIME_W-1:0] queue_time,
	output logic [LEN_W-1:0]  queue_length,
	output logic [DROP_W-1:0] drop_bytes,
	input  logic              cfg_wr_en,
	input  logic [CAP_W-1:0]  cfg_wr_data
);

	logic              accept;
	ctl_t              ctl;
	cnt_t              count;
	cnt_t              count_next;
	logic [DROP_W-1:0] drop_next;
	entry_t            in_entry;
	entry_t            entries [DEPTH];

	logic              out_valid_q;
	status_t           status_q;
	logic [TAG_W-1:0]  tag_q;
	logic [SIZE_W-1:0] size_q;
	logic [TIME_W-1:0] time_q;
	logic [LEN_W-1:0]  len_q;
	logic [DROP_W-1:0] drop_q;

	// handshake: stall only while a result is held
	assign in_stall = out_valid_q && out_stall;
	assign accept = in_valid && !in_stall;

	assign in_entry = '{tag: packet_tag, size: packet_size, arrival: now_time};

	dtpq_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.func        (func),
		.packet_size (packet_size),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.ctl         (ctl),
		.count       (count),
		.count_next  (count_next),
		.drop_next   (drop_next)
	);

	// row of cells, head at index zero
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		entry_t next_entry;
		if (i == DEPTH - 1) begin : g_last
			assign next_entry = entries[i];
		end else begin : g_mid
			assign next_entry = entries[i+1];
		end
		dtpq_cell u_cell (
			.clk        (clk),
			.shift      (ctl.pop),
			.load       (ctl.push && (count == cnt_t'(i))),
			.next_entry (next_entry),
			.in_entry   (in_entry),
			.entry      (entries[i])
		);
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= ctl.status;
			len_q <= LEN_W'(count_next);
			drop_q <= drop_next;
			if (ctl.pop) begin
				tag_q <= entries[0].tag;
				size_q <= entries[0].size;
				time_q <= now_time - entries[0].arrival;
			end else begin
				tag_q <= '0;
				size_q <= '0;
				time_q <= '0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign status = status_q;
	assign out_tag = tag_q;
	assign out_size = size_q;
	assign queue_time = time_q;
	assign queue_length = len_q;
	assign drop_bytes = drop_q;

endmodule

@@ rtl/dtpq_checker.sv @@
module dtpq_checker
	import dtpq_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input logic [1:0]        status,
	input logic [TAG_W-1:0]  out_tag,
	input logic [TIME_W-1:0] queue_time,
	input logic [LEN_W-1:0]  queue_length,
	input logic [DROP_W-1:0] drop_bytes
);

	// held result stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(out_tag))
		else $error("held result changed");

	// back-pressure only while a result is held
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a held result");

	// every accepted transaction produces a result next cycle
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> out_valid)
		else $error("accepted transaction gave no result");

	// non-dequeue results carry no descriptor
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_ENQ || status == ST_DROP || status == ST_EMPTY)
		|-> out_tag == '0 && queue_time == '0)
		else $error("descriptor fields set without a dequeue");

	// drop counter never shrinks across results
	a_drop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && $past(out_valid) && $past(arst_n) |-> drop_bytes >= $past(drop_bytes))
		else $error("drop byte counter decreased");

endmodule

bind drop_tail_packet_queue dtpq_checker u_dtpq_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.status       (status),
	.out_tag      (out_tag),
	.queue_time   (queue_time),
	.queue_length (queue_length),
	.drop_bytes   (drop_bytes)
);
